/* hw/rtl/nps_pkg.sv */
// Shared constants and types for the non-preemptive priority scheduler.
package nps_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = $clog2(MAX_PROCS);
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;

   // Internal time covers the latest arrival plus every burst
   localparam int TIME_W    = ARR_W + CNT_W;

   // Result field widths
   localparam int ID_W      = 5;
   localparam int OUT_T_W   = 21;
   localparam int SUM_W     = 25;

   // One stored process
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
   } proc_entry_type;

   // Scan beat handed from the sequencer to the selector
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             done;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   // Running outcome of one scan
   typedef struct packed {
      logic               found;
      logic               any_left;
      logic [IDX_W-1:0]   idx;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [ARR_W-1:0]   min_arrival;
   } pick_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } sched_state_type;

endpackage

/* hw/rtl/nps_select.sv */
// Selector: folds scanned entries into the best ready process and earliest pending arrival.
module nps_select (
   input  logic                    clock,
   input  logic                    reset,
   input  nps_pkg::scan_ctl_type   scan_ctl,
   input  nps_pkg::proc_entry_type entry,
   input  logic [nps_pkg::TIME_W-1:0] now,
   output nps_pkg::pick_type       pick
);
   import nps_pkg::*;

   pick_type pick_ff;
   pick_type pick_in;
   pick_type base;
   pick_type next_pick;
   logic     arrived;
   logic     beats;

   // Fold one entry into the running pick
   always_comb begin
      base      = scan_ctl.first ? '0 : pick_ff;
      next_pick = base;
      arrived   = TIME_W'(entry.arrival) <= now;
      // Higher priority wins, then earlier arrival; equal keeps the earlier load
      beats     = (entry.prio > base.prio) ||
                  ((entry.prio == base.prio) && (entry.arrival < base.arrival));
      if (scan_ctl.valid && !scan_ctl.done) begin
         if (!base.any_left || (entry.arrival < base.min_arrival)) begin
            next_pick.min_arrival = entry.arrival;
         end
         next_pick.any_left = 1'b1;
         if (arrived && (!base.found || beats)) begin
            next_pick.found   = 1'b1;
            next_pick.idx     = scan_ctl.idx;
            next_pick.arrival = entry.arrival;
            next_pick.burst   = entry.burst;
            next_pick.prio    = entry.prio;
         end
      end
      pick_in = scan_ctl.valid ? next_pick : pick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_ff <= '0;
      end else begin
         pick_ff <= pick_in;
      end
   end

   assign pick = pick_ff;

endmodule

/* hw/rtl/nonpreemptive_priority_scheduler.sv */
// Non-preemptive priority scheduler: loads a batch of processes and emits their completion stats.
// Processes load one item per cycle into the process memory; the item flagged
// last_process closes the batch and scheduling starts from time zero. Each scheduling decision
// scans all n loaded entries through the memory's one read port, one entry per cycle; a
// decision that finds nothing arrived moves time to the earliest pending arrival and scans
// again. Results come out in completion order through an output register; the scan for the
// next decision runs while a result waits, and a decision stalls only while an earlier
// result is still untaken. The totals are nonzero only on the result flagged last_result.
// No new item is taken until the last result of the batch has been produced.
module nonpreemptive_priority_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nps_pkg::ARR_W-1:0]     req_arrival_time,
   input  logic [nps_pkg::BURST_W-1:0]   req_burst_time,
   input  logic [nps_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic                          req_last_process,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nps_pkg::ID_W-1:0]      rsp_process_id,
   output logic [nps_pkg::OUT_T_W-1:0]   rsp_completion_time,
   output logic [nps_pkg::OUT_T_W-1:0]   rsp_turnaround_time,
   output logic [nps_pkg::OUT_T_W-1:0]   rsp_waiting_time,
   output logic [nps_pkg::SUM_W-1:0]     rsp_total_turnaround,
   output logic [nps_pkg::SUM_W-1:0]     rsp_total_waiting,
   output logic                          rsp_last_result
);
   import nps_pkg::*;

   // Process memory
   proc_entry_type mem [MAX_PROCS];
   proc_entry_type rd_entry_ff;
   logic           mem_we;

   sched_state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     emitted_ff, emitted_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [SUM_W-1:0]     sum_tat_ff, sum_tat_in;
   logic [SUM_W-1:0]     sum_wt_ff, sum_wt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [OUT_T_W-1:0]   rsp_ct_ff, rsp_ct_in;
   logic [OUT_T_W-1:0]   rsp_tat_ff, rsp_tat_in;
   logic [OUT_T_W-1:0]   rsp_wt_ff, rsp_wt_in;
   logic [SUM_W-1:0]     rsp_stat_ff, rsp_stat_in;
   logic [SUM_W-1:0]     rsp_swt_ff, rsp_swt_in;
   logic                 rsp_last_ff, rsp_last_in;

   scan_ctl_type         scan_ctl;
   pick_type             pick;
   proc_entry_type       wr_entry;

   logic                 out_free;
   logic                 is_last;
   logic                 fire;
   logic [TIME_W-1:0]    completion;
   logic [TIME_W-1:0]    wait_t;
   logic [TIME_W-1:0]    tat_t;
   logic [SUM_W-1:0]     sum_tat_next;
   logic [SUM_W-1:0]     sum_wt_next;

   assign wr_entry = '{arrival: req_arrival_time, burst: req_burst_time, prio: req_priority_req};

   // Write on load, read on scan; the two never overlap, so no forwarding
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_entry_ff <= mem[addr_ff];
   end

   // Beat for the selector, aligned with the registered read data
   always_comb begin
      scan_ctl.valid = rd_valid_ff;
      scan_ctl.first = (rd_idx_ff == '0);
      scan_ctl.done  = done_ff[rd_idx_ff];
      scan_ctl.idx   = rd_idx_ff;
   end

   nps_select u_select (
      .clock    (clock),
      .reset    (reset),
      .scan_ctl (scan_ctl),
      .entry    (rd_entry_ff),
      .now      (time_ff),
      .pick     (pick)
   );

   // Completion figures for the picked process
   always_comb begin
      completion   = time_ff + TIME_W'(pick.burst);
      wait_t       = time_ff - TIME_W'(pick.arrival);
      tat_t        = wait_t + TIME_W'(pick.burst);
      sum_tat_next = sum_tat_ff + SUM_W'(tat_t);
      sum_wt_next  = sum_wt_ff + SUM_W'(wait_t);
      out_free     = !rsp_valid_ff || rsp_ready;
      is_last      = (emitted_ff + CNT_W'(1)) == count_ff;
   end

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      emitted_in   = emitted_ff;
      addr_in      = addr_ff;
      rd_valid_in  = 1'b0;
      done_in      = done_ff;
      time_in      = time_ff;
      sum_tat_in   = sum_tat_ff;
      sum_wt_in    = sum_wt_ff;
      mem_we       = 1'b0;
      req_ready    = 1'b0;
      fire         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_ct_in    = rsp_ct_ff;
      rsp_tat_in   = rsp_tat_ff;
      rsp_wt_in    = rsp_wt_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_swt_in   = rsp_swt_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Drop the item's data once the store is full
               if (count_ff < CNT_W'(MAX_PROCS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last_process) begin
                  addr_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            addr_in     = addr_ff + IDX_W'(1);
            if (CNT_W'(addr_ff) == (count_ff - CNT_W'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!pick.found) begin
               // Idle: advance time to the earliest pending arrival and rescan
               time_in  = TIME_W'(pick.min_arrival);
               addr_in  = '0;
               state_in = ST_SCAN;
            end else if (out_free) begin
               fire         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_id_in    = ID_W'(CNT_W'(pick.idx) + CNT_W'(1));
               rsp_ct_in    = OUT_T_W'(completion);
               rsp_tat_in   = OUT_T_W'(tat_t);
               rsp_wt_in    = OUT_T_W'(wait_t);
               rsp_last_in  = is_last;
               rsp_stat_in  = is_last ? sum_tat_next : '0;
               rsp_swt_in   = is_last ? sum_wt_next : '0;
               if (is_last) begin
                  // Batch finished: return to the post-reset state
                  count_in   = '0;
                  emitted_in = '0;
                  done_in    = '0;
                  time_in    = '0;
                  sum_tat_in = '0;
                  sum_wt_in  = '0;
                  state_in   = ST_LOAD;
               end else begin
                  done_in[pick.idx] = 1'b1;
                  emitted_in        = emitted_ff + CNT_W'(1);
                  time_in           = completion;
                  sum_tat_in        = sum_tat_next;
                  sum_wt_in         = sum_wt_next;
                  addr_in           = '0;
                  state_in          = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         emitted_ff   <= '0;
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         done_ff      <= '0;
         time_ff      <= '0;
         sum_tat_ff   <= '0;
         sum_wt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         addr_ff      <= addr_in;
         rd_valid_ff  <= rd_valid_in;
         rd_idx_ff    <= addr_ff;
         done_ff      <= done_in;
         time_ff      <= time_in;
         sum_tat_ff   <= sum_tat_in;
         sum_wt_ff    <= sum_wt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_id_ff   <= rsp_id_in;
      rsp_ct_ff   <= rsp_ct_in;
      rsp_tat_ff  <= rsp_tat_in;
      rsp_wt_ff   <= rsp_wt_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_swt_ff  <= rsp_swt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_process_id       = rsp_id_ff;
   assign rsp_completion_time  = rsp_ct_ff;
   assign rsp_turnaround_time  = rsp_tat_ff;
   assign rsp_waiting_time     = rsp_wt_ff;
   assign rsp_total_turnaround = rsp_stat_ff;
   assign rsp_total_waiting    = rsp_swt_ff;
   assign rsp_last_result      = rsp_last_ff;

`ifndef SYNTH
   // Each completed process has exactly one done flag
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      $countones(done_ff) == int'(emitted_ff))
      else $error("done flags disagree with emitted count");

   // A picked process must have arrived and not be done yet
   a_pick_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && pick.found) |->
         (!done_ff[pick.idx] && (TIME_W'(pick.arrival) <= time_ff)))
      else $error("picked process is done or not yet arrived");

   // A decision always sees some pending process
   a_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (pick.any_left && emitted_ff < count_ff))
      else $error("decision with no pending process");

   // The last result leaves the block cleared for the next batch
   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && is_last) |=>
         (count_ff == '0 && time_ff == '0 && done_ff == '0 && state_ff == ST_LOAD))
      else $error("state not cleared after batch");
`endif

endmodule

/* dv/nps_completion_checker.sv */
// Completion checker for the priority scheduler: rebuilds each batch schedule and compares results.
module nps_completion_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [nps_pkg::ARR_W-1:0]   req_arrival_time,
   input  logic [nps_pkg::BURST_W-1:0] req_burst_time,
   input  logic [nps_pkg::PRIO_W-1:0]  req_priority_req,
   input  logic                        req_last_process,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [nps_pkg::ID_W-1:0]    rsp_process_id,
   input  logic [nps_pkg::OUT_T_W-1:0] rsp_completion_time,
   input  logic [nps_pkg::OUT_T_W-1:0] rsp_turnaround_time,
   input  logic [nps_pkg::OUT_T_W-1:0] rsp_waiting_time,
   input  logic [nps_pkg::SUM_W-1:0]   rsp_total_turnaround,
   input  logic [nps_pkg::SUM_W-1:0]   rsp_total_waiting,
   input  logic                        rsp_last_result,
   output int                          fail_count,
   output int                          pending_count
);
   import nps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [OUT_T_W-1:0] completion;
      logic [OUT_T_W-1:0] turnaround;
      logic [OUT_T_W-1:0] waiting;
      logic [SUM_W-1:0]   grand_turnaround;
      logic [SUM_W-1:0]   total_wait;
      logic               last;
   } completion_type;

   logic [ARR_W-1:0]   batch_arrival [MAX_PROCS];
   logic [BURST_W-1:0] batch_burst [MAX_PROCS];
   logic [PRIO_W-1:0]  batch_prio [MAX_PROCS];
   int                 batch_size;
   completion_type     expected_completions [$];
   completion_type     observed;
   completion_type     predicted;

   // Return 1 when loaded entry a is served ahead of loaded entry b
   function automatic bit runs_first(int a, int b);
      if (batch_prio[a] != batch_prio[b]) return batch_prio[a] > batch_prio[b];
      if (batch_arrival[a] != batch_arrival[b]) return batch_arrival[a] < batch_arrival[b];
      return a < b;
   endfunction

   // Run the loaded batch to completion and queue one completion per process
   function automatic void schedule_batch();
      bit             finished [MAX_PROCS];
      logic [31:0]    now;
      logic [31:0]    earliest;
      logic [31:0]    tat;
      logic [31:0]    waited;
      logic [31:0]    tat_sum;
      logic [31:0]    wait_sum;
      int             pick;
      int             completed;
      completion_type entry;
      now       = '0;
      tat_sum   = '0;
      wait_sum  = '0;
      completed = 0;
      foreach (finished[i]) finished[i] = 1'b0;
      while (completed < batch_size) begin
         pick     = -1;
         earliest = '1;
         for (int i = 0; i < batch_size; i++) begin
            if (!finished[i]) begin
               if (32'(batch_arrival[i]) < earliest) earliest = 32'(batch_arrival[i]);
               if (batch_arrival[i] <= now && (pick < 0 || runs_first(i, pick))) pick = i;
            end
         end
         if (pick < 0) begin
            // nothing has arrived: jump to the earliest pending arrival
            now = earliest;
         end else begin
            now             = now + 32'(batch_burst[pick]);
            finished[pick]  = 1'b1;
            tat             = now - 32'(batch_arrival[pick]);
            waited          = tat - 32'(batch_burst[pick]);
            tat_sum         = tat_sum + tat;
            wait_sum        = wait_sum + waited;
            completed++;
            entry            = '0;
            entry.id         = ID_W'(pick + 1);
            entry.completion = now[OUT_T_W-1:0];
            entry.turnaround = tat[OUT_T_W-1:0];
            entry.waiting    = waited[OUT_T_W-1:0];
            if (completed == batch_size) begin
               entry.grand_turnaround = tat_sum[SUM_W-1:0];
               entry.total_wait       = wait_sum[SUM_W-1:0];
               entry.last             = 1'b1;
            end
            expected_completions.push_back(entry);
         end
      end
      batch_size = 0;
   endfunction

   // Absorb accepted items, then check accepted results
   always @(posedge clock) begin
      if (reset) begin
         batch_size = 0;
         fail_count = 0;
         expected_completions.delete();
      end else begin
         if (req_valid && req_ready) begin
            // drop items once the store is full
            if (batch_size < MAX_PROCS) begin
               batch_arrival[batch_size] = req_arrival_time;
               batch_burst[batch_size]   = req_burst_time;
               batch_prio[batch_size]    = req_priority_req;
               batch_size++;
            end
            if (req_last_process) schedule_batch();
         end
         if (rsp_valid && rsp_ready) begin
            observed.id               = rsp_process_id;
            observed.completion       = rsp_completion_time;
            observed.turnaround       = rsp_turnaround_time;
            observed.waiting          = rsp_waiting_time;
            observed.grand_turnaround = rsp_total_turnaround;
            observed.total_wait       = rsp_total_waiting;
            observed.last             = rsp_last_result;
            if (expected_completions.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected completion of process %0d", $time, rsp_process_id);
            end else begin
               predicted = expected_completions.pop_front();
               if (observed.id !== predicted.id || observed.completion !== predicted.completion
                   || observed.turnaround !== predicted.turnaround
                   || observed.waiting !== predicted.waiting
                   || observed.grand_turnaround !== predicted.grand_turnaround
                   || observed.total_wait !== predicted.total_wait
                   || observed.last !== predicted.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: completion mismatch (expected/actual): id %0d/%0d",
                               " completion %0d/%0d turnaround %0d/%0d waiting %0d/%0d",
                               " total turnaround %0d/%0d total_wait %0d/%0d last %0b/%0b"},
                              $time, predicted.id, observed.id,
                              predicted.completion, observed.completion,
                              predicted.turnaround, observed.turnaround,
                              predicted.waiting, observed.waiting,
                              predicted.grand_turnaround, observed.grand_turnaround,
                              predicted.total_wait, observed.total_wait,
                              predicted.last, observed.last);
               end
            end
         end
      end
      pending_count = expected_completions.size();
   end

endmodule

/* dv/nonpreemptive_priority_scheduler_test.sv */
// Top of the priority scheduler testbench: clock, reset, process batches and the verdict.
module nonpreemptive_priority_scheduler_test;
   import nps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      STYLE_CROWDED,
      STYLE_SPREAD,
      STYLE_EDGES
   } batch_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [ARR_W-1:0]   req_arrival_time = '0;
   logic [BURST_W-1:0] req_burst_time = '0;
   logic [PRIO_W-1:0]  req_priority_req = '0;
   logic               req_last_process = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [ID_W-1:0]    rsp_process_id;
   logic [OUT_T_W-1:0] rsp_completion_time;
   logic [OUT_T_W-1:0] rsp_turnaround_time;
   logic [OUT_T_W-1:0] rsp_waiting_time;
   logic [SUM_W-1:0]   rsp_total_turnaround;
   logic [SUM_W-1:0]   rsp_total_waiting;
   logic               rsp_last_result;
   int                 fail_count;
   int                 pending_count;
   int                 stall_pct = 27;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   nonpreemptive_priority_scheduler uut (.*);

   nps_completion_checker checker_inst (.*);

   // Stall the result side at random, except during the calm stretch
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Offer one process after a random gap and hold it until taken
   task automatic send_process(input logic [ARR_W-1:0] arrival,
                               input logic [BURST_W-1:0] burst,
                               input logic [PRIO_W-1:0] prio,
                               input logic closes);
      while ($urandom_range(99) < stall_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_arrival_time <= arrival;
      req_burst_time   <= burst;
      req_priority_req <= prio;
      req_last_process <= closes;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Send one batch whose field values follow the given style
   task automatic send_batch(input int count, input batch_style_type style);
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      for (int i = 0; i < count; i++) begin
         case (style)
            STYLE_CROWDED: begin
               // close arrivals and few priorities: lots of ties
               arrival = ARR_W'($urandom_range(60));
               burst   = ($urandom_range(7) == 0) ? '0 : BURST_W'($urandom_range(1, 30));
               prio    = PRIO_W'($urandom_range(3));
            end
            STYLE_SPREAD: begin
               arrival = ARR_W'($urandom());
               burst   = BURST_W'($urandom());
               prio    = PRIO_W'($urandom());
            end
            default: begin
               arrival = $urandom_range(1) ? 16'hFFFF : ARR_W'($urandom_range(3));
               burst   = $urandom_range(1) ? 16'hFFFF : BURST_W'($urandom_range(2));
               prio    = $urandom_range(1) ? 8'hFF : 8'h00;
            end
         endcase
         send_process(arrival, burst, prio, i == count - 1);
      end
   endtask

   initial begin
      int batch_index;
      int count;
      int random_items;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-process batches at the field extremes
      send_process('0, '0, '0, 1'b1);
      send_process('1, '1, '1, 1'b1);

      // Idle start, then tie-breaks on arrival and on load order
      send_process(16'd5, 16'd3, 8'd9, 1'b0);
      send_process(16'd5, 16'd1, 8'd9, 1'b0);
      send_process(16'd2, 16'd4, 8'd9, 1'b0);
      send_process(16'd4, 16'd2, 8'd9, 1'b0);
      send_process(16'd6, 16'd1, 8'd200, 1'b1);

      // Fill the store, then two items that must be dropped, the second closing the batch
      for (int i = 0; i < MAX_PROCS; i++)
         send_process((i % 3 == 0) ? 16'hFFFF : 16'(i * 100), 16'(16'hFFFF - i),
                      8'((i % 4) * 85), 1'b0);
      send_process(16'd0, 16'd1, 8'hFF, 1'b0);
      send_process(16'd0, 16'd1, 8'hFF, 1'b1);

      // Random batches, mostly small, some overfilled; batches 4 to 7 run without stalls
      random_items = 0;
      batch_index  = 0;
      while (random_items < 95) begin
         stall_pct = (batch_index >= 4 && batch_index < 8) ? 0 : 27;
         if ($urandom_range(9) == 0)
            count = MAX_PROCS + $urandom_range(1, 3);
         else if ($urandom_range(3) == 0)
            count = $urandom_range(9, MAX_PROCS);
         else
            count = $urandom_range(1, 8);
         send_batch(count, batch_style_type'($urandom_range(2)));
         random_items += count;
         batch_index++;
      end
      req_valid <= 1'b0;

      // Drain every expected completion, then give the block time to misbehave
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("nonpreemptive_priority_scheduler verification clean");
      else
         $display("nonpreemptive_priority_scheduler verification failed");
      $finish;
   end

   // Stop a hung run
   initial begin
      #3_000_000;
      $display("nonpreemptive_priority_scheduler verification failed");
      $finish;
   end

endmodule
